### design/traffic_light_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// Traffic light sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("traffic light sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("traffic light sequencer: next-cycle check failed");

`endif

### design/tls_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer package
// Phase codes, register indexes, reset values, lamp tables and shared types.
// ----------------------------------------------------------------------------
package tls_pkg;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK_COUNT = 2'd2;

	localparam logic [7:0]  SHORT_TICKS_RST = 8'd6;
	localparam logic [15:0] LONG_TICKS_RST  = 16'd101;
	localparam logic [3:0]  BLINK_COUNT_RST = 4'd3;

	localparam logic [2:0] PH_BLINK_A_ON  = 3'd0;
	localparam logic [2:0] PH_BLINK_A_OFF = 3'd1;
	localparam logic [2:0] PH_RED_YELLOW  = 3'd2;
	localparam logic [2:0] PH_ALL_RED     = 3'd3;
	localparam logic [2:0] PH_BLINK_B_ON  = 3'd4;
	localparam logic [2:0] PH_BLINK_B_OFF = 3'd5;

	// Lamp bits: yellow, green, red.
	localparam logic [2:0] LAMP_OFF     = 3'b000;
	localparam logic [2:0] LAMP_RED     = 3'b001;
	localparam logic [2:0] LAMP_GREEN   = 3'b010;
	localparam logic [2:0] LAMP_YELLOW  = 3'b100;
	localparam logic [2:0] LAMP_GRN_YEL = 3'b110;
	localparam logic [2:0] LAMP_RED_YEL = 3'b101;

	typedef struct packed {
		logic [7:0]  short_ticks;
		logic [15:0] long_ticks;
		logic [3:0]  blink_count;
	} cfg_t;

	typedef struct packed {
		logic       active;
		logic [2:0] phase;
		logic [3:0] blink_done;
		logic       last_start;
		logic       last_stop;
	} ctrl_t;

	function automatic logic [2:0] lamp_a(input logic [2:0] ph);
		logic [2:0] l;
		case (ph)
			PH_BLINK_A_ON:  l = LAMP_GRN_YEL;
			PH_BLINK_A_OFF: l = LAMP_GREEN;
			PH_RED_YELLOW:  l = LAMP_RED_YEL;
			PH_ALL_RED:     l = LAMP_RED;
			PH_BLINK_B_ON:  l = LAMP_GREEN;
			default:        l = LAMP_OFF;
		endcase
		return l;
	endfunction

	function automatic logic [2:0] lamp_b(input logic [2:0] ph);
		logic [2:0] l;
		case (ph)
			PH_BLINK_A_ON:  l = LAMP_YELLOW;
			PH_ALL_RED:     l = LAMP_RED;
			PH_BLINK_B_ON:  l = LAMP_GREEN;
			PH_BLINK_B_OFF: l = LAMP_GREEN;
			default:        l = LAMP_OFF;
		endcase
		return l;
	endfunction

endpackage

### design/tls_cfg_regs.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer configuration registers
// Holds the phase durations and the blink pair count written over the port.
// ----------------------------------------------------------------------------
module tls_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tls_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output tls_pkg::cfg_t                    cfg
);
	import tls_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks <= SHORT_TICKS_RST;
			cfg_q.long_ticks  <= LONG_TICKS_RST;
			cfg_q.blink_count <= BLINK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_TICKS: cfg_q.short_ticks <= cfg_wdata[7:0];
				REG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_wdata[15:0];
				REG_BLINK_COUNT: cfg_q.blink_count <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/tls_step.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer step logic
// Computes the next sequencer state and the lamp outputs for one tick.
// ----------------------------------------------------------------------------
module tls_step #(
	parameter int TIMER_WIDTH = 16
) (
	input  tls_pkg::cfg_t            cfg,
	input  tls_pkg::ctrl_t           cur,
	input  logic [TIMER_WIDTH-1:0]   cur_tick,
	input  logic                     start_key,
	input  logic                     stop_key,
	output tls_pkg::ctrl_t           nxt,
	output logic [TIMER_WIDTH-1:0]   nxt_tick,
	output logic [2:0]               road_a_lights,
	output logic [2:0]               road_b_lights,
	output logic                     running
);
	import tls_pkg::*;

	localparam logic [TIMER_WIDTH-1:0] TICK_MAX = '1;

	logic [31:0]            short_ext;
	logic [31:0]            long_ext;
	logic [TIMER_WIDTH-1:0] phase_len;
	logic [TIMER_WIDTH-1:0] tick_inc;
	logic [3:0]             bd_inc;
	logic                   pair_end;
	logic                   start_pressed;
	logic                   stop_pressed;

	assign short_ext = {24'd0, cfg.short_ticks};
	assign long_ext  = {16'd0, cfg.long_ticks};
	assign phase_len = (cur.phase == PH_RED_YELLOW || cur.phase == PH_ALL_RED) ?
		long_ext[TIMER_WIDTH-1:0] : short_ext[TIMER_WIDTH-1:0];
	assign tick_inc  = (cur_tick == TICK_MAX) ? cur_tick : cur_tick + TIMER_WIDTH'(1);
	assign bd_inc    = cur.blink_done + 4'd1;
	assign pair_end  = (bd_inc >= cfg.blink_count) || (bd_inc == 4'd0);

	assign start_pressed = start_key && cur.last_start;
	assign stop_pressed  = stop_key && cur.last_stop;

	always_comb begin
		nxt            = cur;
		nxt.last_start = start_key;
		nxt.last_stop  = stop_key;
		nxt_tick       = cur_tick;
		if (cur.active) begin
			if (stop_pressed) begin
				nxt.active     = 1'b0;
				nxt.phase      = PH_BLINK_A_ON;
				nxt.blink_done = 4'd0;
				nxt_tick       = '0;
			end else if (tick_inc >= phase_len) begin
				nxt_tick = '0;
				unique case (cur.phase)
					PH_BLINK_A_ON: begin
						nxt.phase = PH_BLINK_A_OFF;
					end
					PH_BLINK_A_OFF: begin
						nxt.blink_done = pair_end ? 4'd0 : bd_inc;
						nxt.phase      = pair_end ? PH_RED_YELLOW : PH_BLINK_A_ON;
					end
					PH_RED_YELLOW: begin
						nxt.phase = PH_ALL_RED;
					end
					PH_ALL_RED: begin
						nxt.phase      = PH_BLINK_B_ON;
						nxt.blink_done = 4'd0;
					end
					PH_BLINK_B_ON: begin
						nxt.phase = PH_BLINK_B_OFF;
					end
					PH_BLINK_B_OFF: begin
						nxt.blink_done = pair_end ? 4'd0 : bd_inc;
						nxt.phase      = pair_end ? PH_BLINK_A_ON : PH_BLINK_B_ON;
					end
					default: begin
						nxt.phase      = PH_BLINK_A_ON;
						nxt.blink_done = 4'd0;
					end
				endcase
			end else begin
				nxt_tick = tick_inc;
			end
		end else if (start_pressed) begin
			nxt.active     = 1'b1;
			nxt.phase      = PH_BLINK_A_ON;
			nxt.blink_done = 4'd0;
			nxt_tick       = '0;
		end
	end

	assign running       = nxt.active;
	assign road_a_lights = nxt.active ? lamp_a(nxt.phase) : LAMP_OFF;
	assign road_b_lights = nxt.active ? lamp_b(nxt.phase) : LAMP_OFF;

endmodule

### design/traffic_light_sequencer_core.sv
// ----------------------------------------------------------------------------
// Traffic light sequencer core
// Debounced start/stop keys drive a six-phase two-road lamp sequence.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick and yields exactly one result beat with
// the lamp state after that tick. The block sustains one beat per clock while
// the output side does not stall: a tick is registered, its state update is
// combinational logic through the phase, tick counter and blink counter, and
// the result lands in the output register. The tick counter is TIMER_WIDTH
// bits wide; durations are taken modulo 2^TIMER_WIDTH.
`include "traffic_light_sequencer_core_defines.svh"

module traffic_light_sequencer_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tls_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             start_key,
	input  logic                             stop_key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       road_a_lights,
	output logic [2:0]                       road_b_lights,
	output logic                             running
);
	import tls_pkg::*;

	cfg_t                   cfg;
	ctrl_t                  ctrl_q;
	ctrl_t                  ctrl_nxt;
	logic [TIMER_WIDTH-1:0] tick_q;
	logic [TIMER_WIDTH-1:0] tick_nxt;
	logic                   valid_s1;
	logic                   start_s1;
	logic                   stop_s1;
	logic                   adv;
	logic [2:0]             road_a_nxt;
	logic [2:0]             road_b_nxt;
	logic                   running_nxt;
	logic                   out_valid_q;
	logic [2:0]             road_a_q;
	logic [2:0]             road_b_q;
	logic                   running_q;

	tls_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tls_step #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_step (
		.cfg           (cfg),
		.cur           (ctrl_q),
		.cur_tick      (tick_q),
		.start_key     (start_s1),
		.stop_key      (stop_s1),
		.nxt           (ctrl_nxt),
		.nxt_tick      (tick_nxt),
		.road_a_lights (road_a_nxt),
		.road_b_lights (road_b_nxt),
		.running       (running_nxt)
	);

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= start_key;
			stop_s1  <= stop_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			ctrl_q      <= ctrl_nxt;
			tick_q      <= tick_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			road_a_q  <= road_a_nxt;
			road_b_q  <= road_b_nxt;
			running_q <= running_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign road_a_lights = road_a_q;
	assign road_b_lights = road_b_q;
	assign running       = running_q;

	`TLS_ASSERT_NOW(a_idle_clear, !ctrl_q.active, ctrl_q.phase == PH_BLINK_A_ON && tick_q == '0 && ctrl_q.blink_done == 4'd0)
	`TLS_ASSERT_NOW(a_dark_idle, out_valid_q && !running_q, road_a_q == LAMP_OFF && road_b_q == LAMP_OFF)
	`TLS_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(start_s1) && $stable(stop_s1))
	`TLS_ASSERT_NEXT(a_state_hold, !(valid_s1 && adv), $stable(ctrl_q) && $stable(tick_q))

endmodule
